// ----- rtl/ssmc_pkg.sv -----
package ssmc_pkg;

	// Field widths
	localparam int SymW = 8;
	localparam int SumW = 16;
	localparam int StrW = 15;
	localparam int PosW = 16;
	localparam int LenW = 8;

	// Largest correlation magnitude: 192 symbols of magnitude 128.
	localparam logic [StrW-1:0] MaxStrength = 15'd24576;

	// Frame length after reset; a length of zero means the longest frame.
	localparam logic [PosW-1:0] FrameLengthReset = 16'd3640;
	localparam logic [PosW:0]   MaxFrame         = 17'h10000;

	// Register indexes of the configuration port
	localparam logic RegRateMode    = 1'b0;
	localparam logic RegFrameLength = 1'b1;

	// Rate mode codes
	localparam logic [1:0] ModeRate12 = 2'd0;
	localparam logic [1:0] ModeRate13 = 2'd1;
	localparam logic [1:0] ModeRate14 = 2'd2;
	localparam logic [1:0] ModeRate16 = 2'd3;

	// Marker lengths in symbols
	localparam int Len64  = 64;
	localparam int Len96  = 96;
	localparam int Len128 = 128;
	localparam int Len192 = 192;

	// Sync markers, first transmitted bit in the most significant place
	localparam logic [Len64-1:0]  Mark64  = 64'h034776C7272895B0;
	localparam logic [Len96-1:0]  Mark96  = 96'h25D5C0CE8990F6C9461BF79C;
	localparam logic [Len128-1:0] Mark128 = 128'h034776C7272895B0FCB88938D8D76A4F;
	localparam logic [Len192-1:0] Mark192 =
		192'h25D5C0CE8990F6C9461BF79CDA2A3F31766F0936B9E40863;

	// Marker length for a rate mode.
	function automatic logic [LenW-1:0] marker_len(input logic [1:0] mode);
		logic [LenW-1:0] m;
		unique case (mode)
			ModeRate12: m = LenW'(Len64);
			ModeRate13: m = LenW'(Len96);
			ModeRate14: m = LenW'(Len128);
			default:    m = LenW'(Len192);
		endcase
		return m;
	endfunction

endpackage

// ----- rtl/ssmc_if.sv -----
// Soft symbol channel
interface ssmc_sym_if;
	logic                                valid;
	logic                                ready;
	logic signed [ssmc_pkg::SymW-1:0]    soft_symbol;

	modport source (output valid, output soft_symbol, input ready);
	modport sink   (input valid, input soft_symbol, output ready);
endinterface

// Frame result channel
interface ssmc_res_if;
	logic                         valid;
	logic                         ready;
	logic [ssmc_pkg::PosW-1:0]    best_offset;
	logic [ssmc_pkg::StrW-1:0]    best_strength;
	logic                         inverted;
	logic                         aligned;

	modport source (output valid, output best_offset, output best_strength,
		output inverted, output aligned, input ready);
	modport sink   (input valid, input best_offset, input best_strength,
		input inverted, input aligned, output ready);
endinterface

// ----- rtl/soft_sync_marker_correlator_top.sv -----
// Soft sync marker correlator.
// sym_in carries one signed 8-bit soft symbol per item; res_out carries one
// item per frame with the best marker offset, its strength, the polarity
// flag and the aligned flag. rate_mode (index 0) selects the 64, 96, 128 or
// 192 bit marker and frame_length (index 1) sets symbols per frame; both
// are to be written through cfg_we, cfg_index and cfg_data while the block
// idles, which the block itself does not enforce. One symbol is taken every
// cycle unless sym_in.ready is low. Four systolic chains of cells, one per
// marker, each finish a correlation per symbol; the chain head is compared
// against the running best when the symbol's stage register fires, and a
// frame's result is then registered in the output register.
// Reset clears the symbol history held in the chains, the frame position
// and the running best, and restores rate_mode 0 and frame_length 3640.
// A waiting result sits in the output register while symbols keep flowing;
// only when a second frame end is ready behind an untaken result does
// sym_in.ready drop until res_out.ready is seen.
module soft_sync_marker_correlator_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [ssmc_pkg::PosW-1:0]  cfg_data,
	ssmc_sym_if.sink                   sym_in,
	ssmc_res_if.source                 res_out
);

	typedef struct packed {
		logic                      eval;
		logic                      last;
		logic [1:0]                mode;
		logic [ssmc_pkg::PosW-1:0] off;
	} stage_t;

	logic [1:0]                      rate_mode_q;
	logic [ssmc_pkg::PosW-1:0]       frame_length_q;
	logic [ssmc_pkg::PosW-1:0]       pos_q;
	logic                            s1_valid_s1;
	stage_t                          stage_s1;
	stage_t                          stage_d;
	logic [ssmc_pkg::StrW-1:0]       best_strength_q;
	logic [ssmc_pkg::PosW-1:0]       best_offset_q;
	logic                            inverted_q;
	logic                            out_valid_q;
	logic [ssmc_pkg::PosW-1:0]       out_offset_q;
	logic [ssmc_pkg::StrW-1:0]       out_strength_q;
	logic                            out_inverted_q;
	logic                            out_aligned_q;

	logic                            accept;
	logic                            stall;
	logic                            fire;
	logic [ssmc_pkg::PosW:0]         pos_inc;
	logic [ssmc_pkg::PosW:0]         frame_len;
	logic [ssmc_pkg::PosW:0]         mark_len;
	logic signed [ssmc_pkg::SumW-1:0] corr64, corr96, corr128, corr192;
	logic signed [ssmc_pkg::SumW-1:0] corr;
	logic [ssmc_pkg::SumW-1:0]       mag;
	logic                            take;
	logic [ssmc_pkg::StrW-1:0]       next_strength;
	logic [ssmc_pkg::PosW-1:0]       next_offset;
	logic                            next_inverted;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_mode_q    <= ssmc_pkg::ModeRate12;
			frame_length_q <= ssmc_pkg::FrameLengthReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssmc_pkg::RegRateMode:    rate_mode_q    <= cfg_data[1:0];
				ssmc_pkg::RegFrameLength: frame_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: hold input only when a frame end waits behind an untaken result.
	assign stall        = s1_valid_s1 && stage_s1.last && out_valid_q && !res_out.ready;
	assign sym_in.ready = !stall;
	assign accept       = sym_in.valid && !stall;
	assign fire         = s1_valid_s1 && !stall;

	// Frame position and window bookkeeping for the incoming symbol.
	assign pos_inc   = {1'b0, pos_q} + 17'd1;
	assign frame_len = (frame_length_q == '0) ? ssmc_pkg::MaxFrame : {1'b0, frame_length_q};
	assign mark_len  = {{(ssmc_pkg::PosW+1-ssmc_pkg::LenW){1'b0}},
		ssmc_pkg::marker_len(rate_mode_q)};

	always_comb begin
		stage_d.eval = (pos_inc >= mark_len) && (pos_inc < frame_len);
		stage_d.last = (pos_inc >= frame_len);
		stage_d.mode = rate_mode_q;
		stage_d.off  = ssmc_pkg::PosW'(pos_inc - mark_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			s1_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				pos_q <= stage_d.last ? '0 : pos_inc[ssmc_pkg::PosW-1:0];
			end
			if (accept) begin
				s1_valid_s1 <= 1'b1;
			end else if (fire) begin
				s1_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1 <= stage_d;
		end
	end

	// One systolic chain per marker
	ssmc_chain #(.LEN(ssmc_pkg::Len64), .PAT(ssmc_pkg::Mark64)) u_chain64 (
		.clk(clk), .arst_n(arst_n), .shift_en(accept), .sym(sym_in.soft_symbol), .corr(corr64));
	ssmc_chain #(.LEN(ssmc_pkg::Len96), .PAT(ssmc_pkg::Mark96)) u_chain96 (
		.clk(clk), .arst_n(arst_n), .shift_en(accept), .sym(sym_in.soft_symbol), .corr(corr96));
	ssmc_chain #(.LEN(ssmc_pkg::Len128), .PAT(ssmc_pkg::Mark128)) u_chain128 (
		.clk(clk), .arst_n(arst_n), .shift_en(accept), .sym(sym_in.soft_symbol),
		.corr(corr128));
	ssmc_chain #(.LEN(ssmc_pkg::Len192), .PAT(ssmc_pkg::Mark192)) u_chain192 (
		.clk(clk), .arst_n(arst_n), .shift_en(accept), .sym(sym_in.soft_symbol),
		.corr(corr192));

	// Select the correlation of the marker in force when the symbol arrived.
	always_comb begin
		unique case (stage_s1.mode)
			ssmc_pkg::ModeRate12: corr = corr64;
			ssmc_pkg::ModeRate13: corr = corr96;
			ssmc_pkg::ModeRate14: corr = corr128;
			default:              corr = corr192;
		endcase
	end

	// The running best is never negative, so a larger plain correlation is
	// always positive and one magnitude compare covers both polarities.
	assign mag           = corr[ssmc_pkg::SumW-1] ? ssmc_pkg::SumW'(-corr) : corr;
	assign take          = stage_s1.eval && (mag[ssmc_pkg::StrW-1:0] > best_strength_q);
	assign next_strength = take ? mag[ssmc_pkg::StrW-1:0] : best_strength_q;
	assign next_offset   = take ? stage_s1.off : best_offset_q;
	assign next_inverted = take ? corr[ssmc_pkg::SumW-1] : inverted_q;

	// Running best; cleared once a frame's result has been formed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_strength_q <= '0;
			best_offset_q   <= '0;
			inverted_q      <= 1'b0;
		end else if (fire) begin
			if (stage_s1.last) begin
				best_strength_q <= '0;
				best_offset_q   <= '0;
				inverted_q      <= 1'b0;
			end else begin
				best_strength_q <= next_strength;
				best_offset_q   <= next_offset;
				inverted_q      <= next_inverted;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && stage_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && stage_s1.last) begin
			out_offset_q   <= next_offset;
			out_strength_q <= next_strength;
			out_inverted_q <= next_inverted;
			out_aligned_q  <= (next_offset == '0);
		end
	end

	assign res_out.valid         = out_valid_q;
	assign res_out.best_offset   = out_offset_q;
	assign res_out.best_strength = out_strength_q;
	assign res_out.inverted      = out_inverted_q;
	assign res_out.aligned       = out_aligned_q;

	// The best clears after every frame end.
	a_best_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && stage_s1.last |=> best_strength_q == '0 && best_offset_q == '0)
		else $error("running best not cleared after frame end");

	// An offset outside the search leaves the best untouched.
	a_no_eval_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !stage_s1.eval && !stage_s1.last |=> $stable(best_strength_q))
		else $error("best changed on an offset outside the search");

	// The correlation magnitude is bounded by the longest marker.
	a_strength_bound: assert property (@(posedge clk) disable iff (!arst_n)
		best_strength_q <= ssmc_pkg::MaxStrength)
		else $error("best strength out of range");

	// A frame's last symbol returns the position to zero.
	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && stage_d.last |=> pos_q == '0)
		else $error("frame position not restarted");

endmodule

// ----- rtl/ssmc_cell.sv -----
module ssmc_cell #(
	parameter bit WEIGHT = 1'b1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              shift_en,
	input  logic signed [ssmc_pkg::SymW-1:0]  sym,
	input  logic signed [ssmc_pkg::SumW-1:0]  sum_in,
	output logic signed [ssmc_pkg::SumW-1:0]  sum_q
);

	logic signed [ssmc_pkg::SumW-1:0] sym_ext;
	logic signed [ssmc_pkg::SumW-1:0] weighted;

	// A marker bit of one adds the symbol, a bit of zero subtracts it.
	assign sym_ext  = {{(ssmc_pkg::SumW-ssmc_pkg::SymW){sym[ssmc_pkg::SymW-1]}}, sym};
	assign weighted = WEIGHT ? sym_ext : -sym_ext;

	// Partial sum moves one cell towards the head with every item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (shift_en) begin
			sum_q <= sum_in + weighted;
		end
	end

endmodule

// ----- rtl/ssmc_chain.sv -----
module ssmc_chain #(
	parameter int             LEN = 64,
	parameter logic [LEN-1:0] PAT = '0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              shift_en,
	input  logic signed [ssmc_pkg::SymW-1:0]  sym,
	output logic signed [ssmc_pkg::SumW-1:0]  corr
);

	logic signed [ssmc_pkg::SumW-1:0] sums [LEN+1];

	// The tail cell starts from zero; the head holds the full correlation
	// of the window that ends with the latest symbol.
	assign sums[LEN] = '0;
	assign corr      = sums[0];

	for (genvar j = 0; j < LEN; j++) begin : g_cell
		ssmc_cell #(
			.WEIGHT (PAT[j])
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.sym      (sym),
			.sum_in   (sums[j+1]),
			.sum_q    (sums[j])
		);
	end

endmodule
